/* sv/first_fit_heap_allocator_defines.svh */
// assertion macros for the first-fit heap allocator
// expects signals clk and rst in the scope of use
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FFHA_ASSERT_HOLDS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FFHA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ffha_pkg.sv */
// shared types and codes for the first-fit heap allocator
// no dependencies
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int FIELD_W  = 12;
  localparam int STATUS_W = 2;

  // request commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

  typedef struct packed {
    logic               command;
    logic [FIELD_W-1:0] alloc_size;
    logic [FIELD_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  data_offset;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  live_blocks;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_INIT,
    S_AREAD,
    S_AWALK,
    S_ASPLIT,
    S_AMARK,
    S_FCHK,
    S_FWALK,
    S_FCLR,
    S_FNREAD,
    S_FNEXT,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic                load_req;
    logic                heap_init;
    logic                step;
    logic                latch_hdr;
    logic                wr_split;
    logic                wr_mark;
    logic                wr_free;
    logic                rd_next;
    logic                wr_merge;
    logic                live_inc;
    logic                live_dec;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_free;
    logic size_zero;
    logic heap_ready;
    logic free_bad;
    logic fit;
    logic step_end;
    logic at_target;
    logic past_target;
    logic hdr_alloc;
    logic room;
    logic next_in_heap;
    logic out_free;
  } dp_status_t;

endpackage

/* sv/ffha_ctrl.sv */
// request sequencer for the first-fit heap allocator
// depends on ffha_pkg
`timescale 1ns / 1ps

module ffha_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  ffha_pkg::dp_status_t   sts,
  output ffha_pkg::ctrl_cmd_t    cmd
);
  import ffha_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_START;
      end
      S_START: begin
        if (!sts.req_free && sts.size_zero) state_next = S_FINISH;
        else if (!sts.heap_ready) state_next = S_INIT;
        else if (sts.req_free) state_next = S_FCHK;
        else state_next = S_AWALK;
      end
      S_INIT: begin
        state_next = sts.req_free ? S_FCHK : S_AREAD;
      end
      S_AREAD: begin
        state_next = S_AWALK;
      end
      S_AWALK: begin
        if (sts.fit) state_next = S_ASPLIT;
        else if (sts.step_end) state_next = S_FINISH;
      end
      S_ASPLIT: begin
        state_next = S_AMARK;
      end
      S_AMARK: begin
        state_next = S_FINISH;
      end
      S_FCHK: begin
        state_next = sts.free_bad ? S_FINISH : S_FWALK;
      end
      S_FWALK: begin
        if (sts.at_target) state_next = sts.hdr_alloc ? S_FCLR : S_FINISH;
        else if (sts.past_target) state_next = S_FINISH;
      end
      S_FCLR: begin
        state_next = S_FNREAD;
      end
      S_FNREAD: begin
        state_next = sts.next_in_heap ? S_FNEXT : S_FINISH;
      end
      S_FNEXT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = ST_OK;
    req_stall  = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load_req = req_valid;
      end
      S_START: begin
        if (!sts.req_free && sts.size_zero) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_ZERO_SIZE;
        end
      end
      S_INIT: begin
        cmd.heap_init = 1'b1;
      end
      S_AREAD: begin
      end
      S_AWALK: begin
        if (sts.fit) begin
          cmd.latch_hdr = 1'b1;
        end else if (sts.step_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NO_SPACE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_ASPLIT: begin
        cmd.wr_split = sts.room;
      end
      S_AMARK: begin
        cmd.wr_mark    = 1'b1;
        cmd.live_inc   = 1'b1;
        cmd.set_status = 1'b1;
      end
      S_FCHK: begin
        if (sts.free_bad) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_BAD_FREE;
        end
      end
      S_FWALK: begin
        if (sts.at_target) begin
          if (sts.hdr_alloc) begin
            cmd.latch_hdr = 1'b1;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_BAD_FREE;
          end
        end else if (sts.past_target) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_BAD_FREE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FCLR: begin
        cmd.wr_free = 1'b1;
      end
      S_FNREAD: begin
        cmd.rd_next = 1'b1;
        if (!sts.next_in_heap) begin
          cmd.live_dec   = 1'b1;
          cmd.set_status = 1'b1;
        end
      end
      S_FNEXT: begin
        cmd.wr_merge   = !sts.hdr_alloc;
        cmd.live_dec   = 1'b1;
        cmd.set_status = 1'b1;
      end
      S_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/ffha_dp.sv */
// header store, walk registers and result register of the heap allocator
// depends on ffha_pkg
`timescale 1ns / 1ps

module ffha_dp #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ffha_pkg::req_t        req,
  input  ffha_pkg::ctrl_cmd_t   cmd,
  output ffha_pkg::dp_status_t  sts,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output ffha_pkg::rsp_t        rsp
);
  import ffha_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = AW;
  localparam int EW = SW + 1;
  localparam int PW = $clog2(HEAP_BYTES + 1);
  localparam int WW = ((PW > FIELD_W) ? PW : FIELD_W) + 2;
  localparam logic [WW-1:0] HEAP_W = WW'(HEAP_BYTES);
  localparam logic [WW-1:0] HDR_W  = WW'(HEADER_BYTES);
  localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_BYTES - HEADER_BYTES);

  // header store: flag in the top bit, block data size below
  logic [EW-1:0] hdr_mem [HEAP_BYTES];
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic                req_cmd;
  logic [FIELD_W-1:0]  req_size;
  logic [FIELD_W-1:0]  req_offset;
  logic [PW-1:0]       pos;
  logic [PW-1:0]       prev;
  logic [PW-1:0]       base;
  logic [SW-1:0]       hsize;
  logic [SW-1:0]       cur;
  logic [SW-1:0]       prev_size;
  logic                prev_flag;
  logic                has_prev;
  logic                heap_ready;
  logic [FIELD_W-1:0]  live_count;
  logic [FIELD_W-1:0]  res_offset;
  logic [STATUS_W-1:0] res_status;

  logic          rd_flag;
  logic [SW-1:0] rd_size;
  logic [WW-1:0] pos_w;
  logic [WW-1:0] pos_step_w;
  logic [WW-1:0] target_w;
  logic [WW-1:0] split_addr_w;
  logic [WW-1:0] split_size_w;
  logic [WW-1:0] offset_w;
  logic [WW-1:0] merged_w;
  logic [WW-1:0] nxt_w;
  logic [WW-1:0] merge_next_w;
  logic          room;
  logic          prev_free;
  logic [SW-1:0] mark_size;
  logic [SW-1:0] cur_next;
  logic [PW-1:0] base_next;

  assign rd_flag = rdata[EW-1];
  assign rd_size = rdata[SW-1:0];

  always_comb begin
    pos_w        = WW'(pos);
    pos_step_w   = pos_w + WW'(rd_size) + HDR_W;
    target_w     = WW'(req_offset) - HDR_W;
    split_addr_w = pos_w + WW'(req_size) + HDR_W;
    split_size_w = WW'(hsize) - WW'(req_size) - HDR_W;
    offset_w     = pos_w + HDR_W;
    room         = WW'(hsize) >= (WW'(req_size) + HDR_W);
    mark_size    = room ? SW'(req_size) : hsize;
    prev_free    = has_prev && !prev_flag;
    merged_w     = WW'(prev_size) + WW'(hsize) + HDR_W;
    cur_next     = prev_free ? SW'(merged_w) : hsize;
    base_next    = prev_free ? prev : pos;
    nxt_w        = WW'(base) + WW'(cur) + HDR_W;
    merge_next_w = WW'(cur) + WW'(rd_size) + HDR_W;
  end

  // one read address per cycle
  always_comb begin
    if (cmd.step) begin
      raddr = pos_step_w[AW-1:0];
    end else if (cmd.rd_next) begin
      raddr = nxt_w[AW-1:0];
    end else begin
      raddr = pos[AW-1:0];
    end
  end

  // one write per cycle
  always_comb begin
    we    = 1'b1;
    waddr = base[AW-1:0];
    wdata = {1'b0, SW'(merge_next_w)};
    if (cmd.heap_init) begin
      waddr = '0;
      wdata = {1'b0, INIT_SIZE};
    end else if (cmd.wr_split) begin
      waddr = split_addr_w[AW-1:0];
      wdata = {1'b0, SW'(split_size_w)};
    end else if (cmd.wr_mark) begin
      waddr = pos[AW-1:0];
      wdata = {1'b1, mark_size};
    end else if (cmd.wr_free) begin
      waddr = base_next[AW-1:0];
      wdata = {1'b0, cur_next};
    end else if (!cmd.wr_merge) begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      hdr_mem[waddr] <= wdata;
    end
    rdata <= hdr_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_cmd    <= req.command;
      req_size   <= req.alloc_size;
      req_offset <= req.free_offset;
      pos        <= '0;
      has_prev   <= 1'b0;
      res_offset <= '0;
    end else if (cmd.step) begin
      prev      <= pos;
      prev_size <= rd_size;
      prev_flag <= rd_flag;
      has_prev  <= 1'b1;
      pos       <= pos_step_w[PW-1:0];
    end
    if (cmd.latch_hdr) begin
      hsize <= rd_size;
    end
    if (cmd.wr_mark) begin
      res_offset <= offset_w[FIELD_W-1:0];
    end
    if (cmd.wr_free) begin
      base <= base_next;
      cur  <= cur_next;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_ready <= 1'b0;
      live_count <= '0;
    end else begin
      if (cmd.heap_init) heap_ready <= 1'b1;
      if (cmd.live_inc) begin
        live_count <= live_count + FIELD_W'(1);
      end else if (cmd.live_dec) begin
        live_count <= live_count - FIELD_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.data_offset <= res_offset;
      rsp.status      <= res_status;
      rsp.live_blocks <= live_count;
    end
  end

  always_comb begin
    sts.req_free     = (req_cmd == CMD_FREE);
    sts.size_zero    = (req_size == '0);
    sts.heap_ready   = heap_ready;
    sts.free_bad     = (WW'(req_offset) < HDR_W) || (target_w >= HEAP_W);
    sts.fit          = !rd_flag && (WW'(rd_size) >= WW'(req_size));
    sts.step_end     = (pos_step_w >= HEAP_W);
    sts.at_target    = (pos_w == target_w);
    sts.past_target  = (pos_w > target_w);
    sts.hdr_alloc    = rd_flag;
    sts.room         = room;
    sts.next_in_heap = (nxt_w < HEAP_W);
    sts.out_free     = !rsp_valid || !rsp_stall;
  end

endmodule

/* sv/first_fit_heap_allocator.sv */
// first-fit heap allocator with coalescing of free neighbors
// top level: ffha_ctrl sequencer plus ffha_dp header store, uses ffha_pkg
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_defines.svh"

// The block keeps a chain of block headers (allocated flag and data size) in a
// header store with one read port and one write port. One request is worked at
// a time. An allocate walks the headers up to and including the first free
// block that fits (the walk reads one header per cycle). A free walks the
// headers passed before the target block and, when another block follows it
// in the heap, merges that block in if it is free. The first request after
// reset that is not a zero-size allocate also sets up the heap as a single
// free block; an allocate then rereads the first header before its walk. A
// finished result sits in an output register, so it may wait there while the
// next request is already being worked; req_stall is high whenever a request
// is in progress. No clearing pass is needed after reset.

module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 2
) (
  input  logic            clk,
  input  logic            rst,
  // request channel
  input  logic            req_valid,
  output logic            req_stall,
  input  ffha_pkg::req_t  req,
  // result channel
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ffha_pkg::rsp_t  rsp
);
  import ffha_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       header_we;
  logic       err_rsp;

  // sequencer: decides each step of the header walk
  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: header store, walk pointers, counters and result register
  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // any header write this cycle
  assign header_we = cmd.heap_init | cmd.wr_split | cmd.wr_mark | cmd.wr_free |
                     cmd.wr_merge;

  // a waiting result that reports an error
  assign err_rsp = rsp_valid && (rsp.status != ST_OK);

  // a request transfer makes the block busy
  `FFHA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "not busy after request")
  // a result is never loaded over one that is still waiting
  `FFHA_ASSERT_HOLDS(a_no_overwrite, cmd.load_out, sts.out_free, "result overwritten")
  // failed requests report offset zero
  `FFHA_ASSERT_HOLDS(a_err_offset, err_rsp, rsp.data_offset == '0, "nonzero offset on error")
  // only the setup write may touch the store before the heap exists
  `FFHA_ASSERT_HOLDS(a_setup_first, header_we && !sts.heap_ready, cmd.heap_init, "early write")

endmodule

/* bench/tb_first_fit_heap_allocator.sv */
// self-checking bench for first_fit_heap_allocator: a shadow copy of the heap
// computes every response as its request transfers; needs ffha_pkg and the rtl
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 2;
  localparam int SPAN_MASK    = 'h7FFF;          // size part of a block header
  localparam logic [15:0] USED_FLAG = 16'h8000;  // allocated bit of a header
  localparam int RANDOM_REQS  = 630;
  localparam int QUIET_LIMIT  = 20000;           // cycles without any transfer
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 64;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  first_fit_heap_allocator #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // shadow heap: one header per byte position, meaningful only at block starts
  logic [15:0]        shadow_hdr [HEAP_BYTES];
  bit                 heap_built = 1'b0;
  logic [FIELD_W-1:0] shadow_live = '0;
  int                 live_offsets[$];    // data offsets currently allocated
  int                 last_released = 2;  // handy target for a double free

  req_t req_backlog[$];   // requests waiting for the driver
  rsp_t results_due[$];   // responses owed by the block, oldest first

  int errors   = 0;
  int rsp_seen = 0;
  bit steady_send = 1'b0;  // no sender gaps while set
  bit steady_recv = 1'b0;  // no receiver stalls while set

  function automatic logic [15:0] hdr_at(int pos);
    return (pos >= HEAP_BYTES) ? 16'h0000 : shadow_hdr[pos];
  endfunction

  // first use of the heap: a single free block spanning everything
  function automatic void build_heap();
    foreach (shadow_hdr[i]) shadow_hdr[i] = '0;
    shadow_hdr[0] = 16'(HEAP_BYTES - HEADER_BYTES);
    heap_built = 1'b1;
  endfunction

  // applies one request to the shadow heap and returns the response it owes
  function automatic rsp_t heap_apply(req_t r);
    rsp_t        res;
    int          pos, prev, span, sz, target, nxt;
    bit          found, has_prev;
    logic [15:0] h;
    res = '0;
    if (r.command == CMD_ALLOC) begin
      sz = int'(r.alloc_size);
      if (sz == 0) begin
        // zero size: nothing happens, heap stays unbuilt
        res.status = ST_ZERO_SIZE;
      end else begin
        if (!heap_built) build_heap();
        pos   = 0;
        found = 1'b0;
        span  = 0;
        // first fit: walk the chain until a free block is large enough
        while (!found && pos < HEAP_BYTES) begin
          h    = hdr_at(pos);
          span = h & SPAN_MASK;
          if (span >= sz && !h[15]) found = 1'b1;
          else pos += span + HEADER_BYTES;
        end
        if (!found) begin
          res.status = ST_NO_SPACE;
        end else begin
          // split only when the rest can hold a header; may leave a zero-size block
          if (span >= sz + HEADER_BYTES) begin
            shadow_hdr[pos + sz + HEADER_BYTES] = 16'(span - sz - HEADER_BYTES);
            span = sz;
          end
          shadow_hdr[pos] = 16'(span) | USED_FLAG;
          shadow_live++;
          res.status      = ST_OK;
          res.data_offset = 12'(pos + HEADER_BYTES);
          live_offsets.push_back(pos + HEADER_BYTES);
        end
      end
    end else begin
      if (!heap_built) build_heap();
      res.status = ST_BAD_FREE;
      target     = int'(r.free_offset) - HEADER_BYTES;
      if (target >= 0) begin
        pos      = 0;
        prev     = 0;
        has_prev = 1'b0;
        while (pos < target) begin
          prev     = pos;
          has_prev = 1'b1;
          h        = hdr_at(pos);
          pos     += (h & SPAN_MASK) + HEADER_BYTES;
        end
        h = hdr_at(pos);
        if (pos == target && h[15]) begin
          span            = h & SPAN_MASK;
          shadow_hdr[pos] = 16'(span);
          // merge into a free predecessor
          h = hdr_at(prev);
          if (has_prev && !h[15]) begin
            span             = (h & SPAN_MASK) + span + HEADER_BYTES;
            shadow_hdr[prev] = 16'(span & SPAN_MASK);
            pos              = prev;
          end
          // absorb a free successor
          nxt = pos + span + HEADER_BYTES;
          h   = hdr_at(nxt);
          if (nxt < HEAP_BYTES && !h[15]) begin
            span            = span + (h & SPAN_MASK) + HEADER_BYTES;
            shadow_hdr[pos] = 16'(span & SPAN_MASK);
          end
          shadow_live--;
          res.status    = ST_OK;
          last_released = int'(r.free_offset);
          for (int i = 0; i < live_offsets.size(); i++) begin
            if (live_offsets[i] == int'(r.free_offset)) begin
              live_offsets.delete(i);
              break;
            end
          end
        end
      end
    end
    res.live_blocks = shadow_live;
    return res;
  endfunction

  // idle stretch length: mostly short, now and then long
  function automatic int idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // request sender: holds the payload while stalled, inserts random gaps
  bit offer;
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst) begin
      offer = req_valid;
      if (req_valid && !req_stall) begin
        // transfer on the request side: account for its response now
        results_due.push_back(heap_apply(req));
        offer    = 1'b0;
        send_gap = (steady_send || $urandom_range(0, 99) >= 35) ? 0 : idle_len();
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_backlog.size() > 0) begin
          req <= req_backlog.pop_front();
          offer = 1'b1;
        end
      end
      req_valid <= offer;
    end
  end

  // response checker and receiver stall pattern
  rsp_t want;
  bit   stall_next;
  int   hold_left      = 0;
  bit   long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        rsp_seen++;
        if (results_due.size() == 0) begin
          $display("%0t: response with nothing outstanding: offset %0d status %0d live %0d",
                   $time, rsp.data_offset, rsp.status, rsp.live_blocks);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (rsp.data_offset !== want.data_offset) begin
            $display("%0t: data_offset expected %0d actual %0d",
                     $time, want.data_offset, rsp.data_offset);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            errors++;
          end
          if (rsp.live_blocks !== want.live_blocks) begin
            $display("%0t: live_blocks expected %0d actual %0d",
                     $time, want.live_blocks, rsp.live_blocks);
            errors++;
          end
        end
      end
      // one long hold-off lets the block back up and stall its request side
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (!long_hold_done && rsp_seen >= 150) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        stall_next     = 1'b1;
      end else if (!steady_recv && $urandom_range(0, 99) < 20) begin
        hold_left  = idle_len() - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      rsp_stall <= stall_next;
    end
  end

  // watchdog: ends the run if nothing transfers for too long
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
    else quiet++;
    if (quiet == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // feeds the backlog a couple of requests ahead of the driver;
  // the field a command ignores gets random content
  task automatic queue_req(logic cmd, int val);
    req_t r;
    r.command     = cmd;
    r.alloc_size  = (cmd == CMD_ALLOC) ? 12'(val) : 12'($urandom);
    r.free_offset = (cmd == CMD_FREE) ? 12'(val) : 12'($urandom);
    while (req_backlog.size() >= 2) @(negedge clk);
    req_backlog.push_back(r);
  endtask

  task automatic wait_all_done();
    while (req_backlog.size() != 0 || req_valid || results_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    int roll, pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: corners of the chain and of each error path
    queue_req(CMD_ALLOC, 0);                   // zero size before the heap exists
    queue_req(CMD_FREE, 0);                    // builds heap, offset below header
    queue_req(CMD_ALLOC, 4095);                // larger than the single free block
    queue_req(CMD_ALLOC, HEAP_BYTES - 2);      // exact fit of the whole heap
    queue_req(CMD_ALLOC, 1);                   // heap full
    queue_req(CMD_FREE, 2);
    queue_req(CMD_FREE, 2);                    // double free
    queue_req(CMD_ALLOC, HEAP_BYTES - 4);      // split leaves a zero-size block
    queue_req(CMD_ALLOC, 1);                   // zero-size block does not fit
    queue_req(CMD_FREE, 4095);                 // lands inside a block
    queue_req(CMD_FREE, 2);                    // merges with zero-size successor
    queue_req(CMD_ALLOC, 100);
    queue_req(CMD_ALLOC, 200);
    queue_req(CMD_ALLOC, 300);
    queue_req(CMD_FREE, 104);                  // both neighbors allocated
    queue_req(CMD_FREE, 105);                  // not a block start
    queue_req(CMD_FREE, 2);                    // merges forward
    queue_req(CMD_FREE, 306);                  // merges both ways
    queue_req(CMD_FREE, 1);                    // below header
    queue_req(CMD_ALLOC, HEAP_BYTES - 2);
    queue_req(CMD_FREE, 2);

    // random mix, mostly legal frees of live blocks
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 2) wait_all_done();
      if (n % 80 == 0) begin
        steady_send = ($urandom_range(0, 2) == 0);
        steady_recv = ($urandom_range(0, 2) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < ((live_offsets.size() > 40) ? 30 : 55)) begin
        roll = $urandom_range(0, 99);
        if (roll < 70)      queue_req(CMD_ALLOC, $urandom_range(1, 48));
        else if (roll < 90) queue_req(CMD_ALLOC, $urandom_range(49, 400));
        else if (roll < 96) queue_req(CMD_ALLOC, $urandom_range(0, 4095));
        else                queue_req(CMD_ALLOC, 0);
      end else begin
        roll = $urandom_range(0, 99);
        pick = (live_offsets.size() > 0) ?
               live_offsets[$urandom_range(0, live_offsets.size() - 1)] : 2;
        if (roll < 80)      queue_req(CMD_FREE, pick);
        else if (roll < 88) queue_req(CMD_FREE, $urandom_range(0, 4095));
        else if (roll < 94) queue_req(CMD_FREE, pick + 1);
        else                queue_req(CMD_FREE, last_released);
      end
    end

    wait_all_done();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
